### rtl/core/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg: shared types and constants for the epoch to calendar date block
// Holds the time constants and the month length table of the datapath, and the
// command and status bundles that the controller and the datapath both use.
// ----------------------------------------------------------------------------
package ecd_pkg;

   localparam logic [31:0] SECS_LEAP_YEAR   = 32'd31622400;
   localparam logic [31:0] SECS_COMMON_YEAR = 32'd31536000;
   localparam logic [31:0] SECS_PER_DAY     = 32'd86400;
   localparam logic [31:0] SECS_PER_HOUR    = 32'd3600;
   localparam logic [31:0] SECS_PER_MINUTE  = 32'd60;
   localparam logic [31:0] MS_PER_SECOND    = 32'd1000;
   localparam logic [11:0] BASE_YEAR        = 12'd1970;

   // Reciprocals for the divisions by constants. Each quotient is the top
   // bits of one product: milliseconds times MS_RECIP over 2^38, seconds of
   // the month over 2^7 times DAY_RECIP over 2^25, seconds of the day over
   // 2^4 times HOUR_RECIP over 2^21, seconds of the hour over 2^2 times
   // MINUTE_RECIP over 2^14. The rounding error stays below one quotient
   // step over the whole range that each input can take.
   localparam logic [28:0] MS_RECIP     = 29'd274877907;
   localparam logic [15:0] DAY_RECIP    = 16'd49711;
   localparam logic [13:0] HOUR_RECIP   = 14'd9321;
   localparam logic [10:0] MINUTE_RECIP = 11'd1093;

   // Position of the base year in the 4, 100 and 400 year leap cycles.
   localparam logic [1:0] BASE_MOD4   = 2'd2;
   localparam logic [6:0] BASE_MOD100 = 7'd70;
   localparam logic [8:0] BASE_MOD400 = 9'd370;

   localparam logic [3:0] LAST_MONTH = 4'd12;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_MSDIV,
      OP_ADD,
      OP_YEAR,
      OP_MONTH,
      OP_DAY,
      OP_DAY_REM,
      OP_HOUR,
      OP_HOUR_REM,
      OP_MINUTE,
      OP_MINUTE_REM
   } op_type;

   typedef struct packed {
      logic       load;
      op_type     op;
      logic       capture;
   } cmd_type;

   typedef struct packed {
      logic time_valid;
      logic year_done;
      logic month_done;
   } status_type;

   // Length of a month in seconds.
   function automatic logic [31:0] month_secs(input logic [3:0] month, input logic leap);
      logic [31:0] secs;
      case (month)
         4'd2: begin
            secs = leap ? 32'd2505600 : 32'd2419200;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            secs = 32'd2592000;
         end
         default: begin
            secs = 32'd2678400;
         end
      endcase
      return secs;
   endfunction

endpackage

### rtl/core/ecd_ctrl.sv
// ----------------------------------------------------------------------------
// ecd_ctrl: sequencer for the epoch to calendar date block
// Steps the datapath through the millisecond division, the year and month
// loops and the split of the remaining seconds, and owns the result valid
// flag.
// ----------------------------------------------------------------------------
module ecd_ctrl import ecd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_MSDIV,
      S_ADD,
      S_YEAR,
      S_MONTH,
      S_DAY,
      S_DAY_REM,
      S_HOUR,
      S_HOUR_REM,
      S_MINUTE,
      S_MINUTE_REM,
      S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.op       = OP_NONE;
      cmd.capture  = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = status.time_valid ? S_MSDIV : S_FINISH;
         end
         S_MSDIV: begin
            cmd.op   = OP_MSDIV;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.op   = OP_ADD;
            state_in = S_YEAR;
         end
         S_YEAR: begin
            cmd.op = OP_YEAR;
            if (status.year_done) begin
               state_in = S_MONTH;
            end
         end
         S_MONTH: begin
            cmd.op = OP_MONTH;
            if (status.month_done) begin
               state_in = S_DAY;
            end
         end
         S_DAY: begin
            cmd.op   = OP_DAY;
            state_in = S_DAY_REM;
         end
         S_DAY_REM: begin
            cmd.op   = OP_DAY_REM;
            state_in = S_HOUR;
         end
         S_HOUR: begin
            cmd.op   = OP_HOUR;
            state_in = S_HOUR_REM;
         end
         S_HOUR_REM: begin
            cmd.op   = OP_HOUR_REM;
            state_in = S_MINUTE;
         end
         S_MINUTE: begin
            cmd.op   = OP_MINUTE;
            state_in = S_MINUTE_REM;
         end
         S_MINUTE_REM: begin
            cmd.op   = OP_MINUTE_REM;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.capture  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/ecd_datapath.sv
// ----------------------------------------------------------------------------
// ecd_datapath: arithmetic for the epoch to calendar date block
// Reciprocal multiplications for the divisions by constants, the epoch add,
// year and month removal, the day, hour and minute remainders, plus the
// result registers.
// ----------------------------------------------------------------------------
module ecd_datapath import ecd_pkg::*; (
   input  logic        clock,
   input  logic [31:0] req_epoch_at_sync,
   input  logic [31:0] req_elapsed_ms,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_time_valid,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic [9:0]  rsp_millisecond
);

   logic [31:0] epoch_ff, epoch_in;
   logic [31:0] ems_ff, ems_in;
   logic [22:0] msq_ff, msq_in;
   logic [9:0]  msrem_ff, msrem_in;
   logic [31:0] secs_ff, secs_in;
   logic        tvalid_ff, tvalid_in;
   logic [11:0] year_ff, year_in;
   logic [1:0]  mod4_ff, mod4_in;
   logic [6:0]  mod100_ff, mod100_in;
   logic [8:0]  mod400_ff, mod400_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  dayq_ff, dayq_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;

   logic        o_tvalid_ff, o_tvalid_in;
   logic [11:0] o_year_ff, o_year_in;
   logic [3:0]  o_month_ff, o_month_in;
   logic [4:0]  o_day_ff, o_day_in;
   logic [4:0]  o_hour_ff, o_hour_in;
   logic [5:0]  o_minute_ff, o_minute_in;
   logic [5:0]  o_second_ff, o_second_in;
   logic [9:0]  o_ms_ff, o_ms_in;

   logic        leap;
   logic [31:0] ylen;
   logic [31:0] mlen;
   logic [60:0] ms_prod;
   logic [31:0] ms_back;
   logic [31:0] ms_rem;
   logic [30:0] day_prod;
   logic [31:0] day_back;
   logic [26:0] hour_prod;
   logic [31:0] hour_back;
   logic [20:0] minute_prod;
   logic [31:0] minute_back;

   assign leap = ((mod4_ff == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);
   assign ylen = leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
   assign mlen = month_secs(month_ff, leap);

   // Quotients come from one product each; each remainder is taken in the state
   // after its quotient, from the registered quotient.
   assign ms_prod     = {29'd0, ems_ff} * {32'd0, MS_RECIP};
   assign ms_back     = {9'd0, msq_ff} * MS_PER_SECOND;
   assign ms_rem      = ems_ff - ms_back;
   assign day_prod    = {16'd0, secs_ff[21:7]} * {15'd0, DAY_RECIP};
   assign day_back    = {27'd0, dayq_ff} * SECS_PER_DAY;
   assign hour_prod   = {14'd0, secs_ff[16:4]} * {13'd0, HOUR_RECIP};
   assign hour_back   = {27'd0, hour_ff} * SECS_PER_HOUR;
   assign minute_prod = {11'd0, secs_ff[11:2]} * {10'd0, MINUTE_RECIP};
   assign minute_back = {26'd0, minute_ff} * SECS_PER_MINUTE;

   assign status.time_valid = tvalid_ff;
   assign status.year_done  = (secs_ff < ylen);
   assign status.month_done = (month_ff == LAST_MONTH) || (secs_ff < mlen);

   always_comb begin
      epoch_in  = epoch_ff;
      ems_in    = ems_ff;
      msq_in    = msq_ff;
      msrem_in  = msrem_ff;
      secs_in   = secs_ff;
      tvalid_in = tvalid_ff;
      year_in   = year_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      month_in  = month_ff;
      dayq_in   = dayq_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      if (cmd.load) begin
         epoch_in  = req_epoch_at_sync;
         ems_in    = req_elapsed_ms;
         msq_in    = 23'd0;
         msrem_in  = 10'd0;
         tvalid_in = (req_epoch_at_sync != 32'd0);
         year_in   = BASE_YEAR;
         mod4_in   = BASE_MOD4;
         mod100_in = BASE_MOD100;
         mod400_in = BASE_MOD400;
         month_in  = 4'd1;
         dayq_in   = 5'd0;
         hour_in   = 5'd0;
         minute_in = 6'd0;
      end
      case (cmd.op)
         OP_MSDIV: begin
            msq_in = ms_prod[60:38];
         end
         OP_ADD: begin
            // The remainder is below 1000, so its low ten bits are all of it.
            secs_in  = epoch_ff + {9'd0, msq_ff};
            msrem_in = ms_rem[9:0];
         end
         OP_YEAR: begin
            if (!status.year_done) begin
               secs_in   = secs_ff - ylen;
               year_in   = year_ff + 12'd1;
               mod4_in   = mod4_ff + 2'd1;
               mod100_in = (mod100_ff == 7'd99) ? 7'd0 : mod100_ff + 7'd1;
               mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 9'd1;
            end
         end
         OP_MONTH: begin
            if (!status.month_done) begin
               secs_in  = secs_ff - mlen;
               month_in = month_ff + 4'd1;
            end
         end
         OP_DAY: begin
            dayq_in = day_prod[29:25];
         end
         OP_DAY_REM: begin
            secs_in = secs_ff - day_back;
         end
         OP_HOUR: begin
            hour_in = hour_prod[25:21];
         end
         OP_HOUR_REM: begin
            secs_in = secs_ff - hour_back;
         end
         OP_MINUTE: begin
            minute_in = minute_prod[19:14];
         end
         OP_MINUTE_REM: begin
            secs_in = secs_ff - minute_back;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      o_tvalid_in = o_tvalid_ff;
      o_year_in   = o_year_ff;
      o_month_in  = o_month_ff;
      o_day_in    = o_day_ff;
      o_hour_in   = o_hour_ff;
      o_minute_in = o_minute_ff;
      o_second_in = o_second_ff;
      o_ms_in     = o_ms_ff;
      if (cmd.capture) begin
         // A time that was never loaded reads as all zeros.
         o_tvalid_in = tvalid_ff;
         o_year_in   = tvalid_ff ? year_ff : 12'd0;
         o_month_in  = tvalid_ff ? month_ff : 4'd0;
         o_day_in    = tvalid_ff ? dayq_ff + 5'd1 : 5'd0;
         o_hour_in   = tvalid_ff ? hour_ff : 5'd0;
         o_minute_in = tvalid_ff ? minute_ff : 6'd0;
         o_second_in = tvalid_ff ? secs_ff[5:0] : 6'd0;
         o_ms_in     = tvalid_ff ? msrem_ff : 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      epoch_ff    <= epoch_in;
      ems_ff      <= ems_in;
      msq_ff      <= msq_in;
      msrem_ff    <= msrem_in;
      secs_ff     <= secs_in;
      tvalid_ff   <= tvalid_in;
      year_ff     <= year_in;
      mod4_ff     <= mod4_in;
      mod100_ff   <= mod100_in;
      mod400_ff   <= mod400_in;
      month_ff    <= month_in;
      dayq_ff     <= dayq_in;
      hour_ff     <= hour_in;
      minute_ff   <= minute_in;
      o_tvalid_ff <= o_tvalid_in;
      o_year_ff   <= o_year_in;
      o_month_ff  <= o_month_in;
      o_day_ff    <= o_day_in;
      o_hour_ff   <= o_hour_in;
      o_minute_ff <= o_minute_in;
      o_second_ff <= o_second_in;
      o_ms_ff     <= o_ms_in;
   end

   assign rsp_time_valid  = o_tvalid_ff;
   assign rsp_year        = o_year_ff;
   assign rsp_month       = o_month_ff;
   assign rsp_day         = o_day_ff;
   assign rsp_hour        = o_hour_ff;
   assign rsp_minute      = o_minute_ff;
   assign rsp_second      = o_second_ff;
   assign rsp_millisecond = o_ms_ff;

endmodule

### rtl/core/epoch_to_calendar_date.sv
// Timing: an epoch of zero skips the conversion steps; otherwise the year
//   and month loops run once for each whole year past 1970 (up to 136) and
//   each whole month in the final year (up to 11).
// Throughput: one item at a time; the next item is taken once the result is
//   in the output register, even if stalled.
// Reset: synchronous, active high; clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
// epoch_to_calendar_date: Unix time to Gregorian calendar date converter
// Adds the whole seconds of the elapsed milliseconds to the synced epoch and
// breaks the sum into year, month, day, hour, minute and second.
// ----------------------------------------------------------------------------
//
// The work splits into a sequencer (ecd_ctrl) and an arithmetic datapath
// (ecd_datapath) that talk only through a command and a status bundle.
//
// Per item the sequencer runs these steps:
//   1. The elapsed milliseconds are divided by 1000 with one reciprocal
//      multiplication.
//   2. The quotient is added to the epoch, wrapping at 32 bits, and the
//      millisecond remainder is taken in the same cycle.
//   3. Whole years are subtracted one per cycle from 1970 on. The leap rule
//      uses counters that track the year modulo 4, 100 and 400, so no
//      divider on the year is needed. The year loop sets the worst case.
//   4. Whole months are subtracted one per cycle, at most eleven times.
//   5. The rest is split into days, hours and minutes: for each, a
//      reciprocal multiplication gives the quotient, then its multiple is
//      subtracted. What remains is the second.
// An epoch of zero skips all of this and yields an all-zero item.
//
// The result sits in an output register until it is taken, and the input
// side opens again as soon as that register has been loaded. If the previous
// result is still stalled when a new one is ready, the sequencer waits.
module epoch_to_calendar_date import ecd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_epoch_at_sync,
   input  logic [31:0] req_elapsed_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_time_valid,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic [9:0]  rsp_millisecond
);

   cmd_type    cmd;
   status_type status;

   // Sequencer: owns the state and the result valid flag.
   ecd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: working registers, the multiply, subtract and compare logic
   // and the result register.
   ecd_datapath u_datapath (
      .clock             (clock),
      .req_epoch_at_sync (req_epoch_at_sync),
      .req_elapsed_ms    (req_elapsed_ms),
      .cmd               (cmd),
      .status            (status),
      .rsp_time_valid    (rsp_time_valid),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_millisecond   (rsp_millisecond)
   );

endmodule

### rtl/core/ecd_checker.sv
// ----------------------------------------------------------------------------
// ecd_checker: port-level checks for the epoch to calendar date block
// Watches the ports of the top level over time and flags results that no
// correct conversion can give.
// ----------------------------------------------------------------------------
module ecd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [31:0] req_epoch_at_sync,
   input logic [31:0] req_elapsed_ms,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_time_valid,
   input logic [11:0] rsp_year,
   input logic [3:0]  rsp_month,
   input logic [4:0]  rsp_day,
   input logic [4:0]  rsp_hour,
   input logic [5:0]  rsp_minute,
   input logic [5:0]  rsp_second,
   input logic [9:0]  rsp_millisecond
);

   // An item without a loaded time carries only zeros.
   a_unloaded_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_time_valid) |->
         (rsp_year == 12'd0) && (rsp_month == 4'd0) && (rsp_day == 5'd0) &&
         (rsp_hour == 5'd0) && (rsp_minute == 6'd0) && (rsp_second == 6'd0) &&
         (rsp_millisecond == 10'd0))
      else $error("unloaded time gave a nonzero field");

   // A loaded time gives every field within its calendar range.
   a_fields_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_time_valid) |->
         (rsp_year >= 12'd1970) && (rsp_year <= 12'd2106) &&
         (rsp_month >= 4'd1) && (rsp_month <= 4'd12) && (rsp_day >= 5'd1) &&
         (rsp_hour <= 5'd23) && (rsp_minute <= 6'd59) && (rsp_second <= 6'd59) &&
         (rsp_millisecond <= 10'd999))
      else $error("result field out of range");

   // The block works on one item at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while an item is in progress");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         rsp_valid && $stable(rsp_time_valid) && $stable(rsp_year) &&
         $stable(rsp_month) && $stable(rsp_day) && $stable(rsp_hour) &&
         $stable(rsp_minute) && $stable(rsp_second) && $stable(rsp_millisecond))
      else $error("stalled result changed");

endmodule

bind epoch_to_calendar_date ecd_checker u_ecd_checker (.*);
